>>> design/lpd_pkg.sv
// Shared types, widths and mode codes for the Lp distance block.
package lpd_pkg;

    localparam int ELEM_BITS   = 16;
    localparam int FRAC        = 8;
    localparam int SUM_W       = 48;
    localparam int TERM_W      = 2 * ELEM_BITS + FRAC;
    localparam int MUL_W       = 28;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SQ_IN_W     = 56;
    localparam int SQ_ROOT_W   = SQ_IN_W / 2;
    localparam int GROUP_SIZE_DEF = 8;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_L1  = 2'd0,
        MODE_L2  = 2'd1,
        MODE_L05 = 2'd2
    } norm_t;

    typedef struct packed {
        logic signed [ELEM_BITS-1:0] elem_a;
        logic signed [ELEM_BITS-1:0] elem_b;
        logic        [SUM_W-1:0]     abandon_limit;
        logic                        vec_last;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0] distance;
        logic             abandoned;
    } result_t;

    // One classified word as it waits between the front and the back.
    typedef struct packed {
        logic [ELEM_BITS-1:0] diff;
        logic [SUM_W-1:0]     limit;
        logic                 last;
        norm_t                mode;
    } entry_t;

endpackage

>>> design/lpd_front.sv
// Front end: accepts words, forms |a-b| and the mode, and queues them for the back end.
module lpd_front
    import lpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    input  logic [1:0] norm_mode,
    output logic       q_valid,
    output entry_t     q_entry,
    input  logic       q_pop
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    entry_t     new_entry;
    logic signed [ELEM_BITS:0] diff_s;

    assign item_ready = (count_reg != 2'd2);
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_entry    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        diff_s = (ELEM_BITS+1)'(item.elem_a) - (ELEM_BITS+1)'(item.elem_b);
        new_entry.diff  = diff_s[ELEM_BITS] ? ELEM_BITS'(-diff_s) : ELEM_BITS'(diff_s);
        new_entry.limit = item.abandon_limit;
        new_entry.last  = item.vec_last;
        case (norm_mode)
            MODE_L2:  new_entry.mode = MODE_L2;
            MODE_L05: new_entry.mode = MODE_L05;
            default:  new_entry.mode = MODE_L1;
        endcase
        count_next = count_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> design/lpd_sqrt.sv
// Iterative integer square root, two operand bits per cycle.
module lpd_sqrt
    import lpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SQ_IN_W-1:0]   operand,
    output logic                 done,
    output logic [SQ_ROOT_W-1:0] root
);

    localparam int RW    = SQ_ROOT_W + 3;
    localparam int CNT_W = $clog2(SQ_ROOT_W);

    logic [SQ_IN_W-1:0]   op_reg;
    logic [RW-1:0]        rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        trial;

    assign done = done_reg;
    assign root = root_reg;

    always_comb
    begin
        rem_sh = {rem_reg[RW-3:0], op_reg[SQ_IN_W-1 -: 2]};
        trial  = RW'({root_reg, 2'b01});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg <= op_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> design/lpd_back.sv
// Back end: limit conversion, per-element term, accumulation, group checks and final value.
module lpd_back
    import lpd_pkg::*;
#(
    parameter int GROUP_SIZE = GROUP_SIZE_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  entry_t  q_entry,
    output logic    q_pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int GCW   = $clog2(GROUP_SIZE + 1);
    localparam int ACC_W = ((TERM_W > SUM_W) ? TERM_W : SUM_W) + 1;
    localparam logic [SUM_W-1:0] SQ_LIMIT = SUM_W'(1) << MUL_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LIMIT, ST_LIM_MUL, ST_LIM_PROD, ST_LIM_SQRT,
        ST_TERM, ST_TERM_MUL, ST_TERM_PROD, ST_TERM_SQRT, ST_ACC,
        ST_FIN, ST_FIN_MUL, ST_FIN_PROD, ST_FIN_SQRT, ST_OUT
    } state_t;

    state_t               state_reg;
    entry_t               entry_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     limit_reg;
    logic [TERM_W-1:0]    term_reg;
    logic [SUM_W-1:0]     res_reg;
    logic [GCW-1:0]       gcnt_reg;
    logic                 abandon_reg;
    logic                 start_reg;
    logic                 pop_reg;
    logic [MUL_W-1:0]     mul_op_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 sq_start_reg;
    logic [SQ_IN_W-1:0]   sq_op_reg;
    logic                 sq_done;
    logic [SQ_ROOT_W-1:0] sq_root;
    logic                 result_valid_reg;
    result_t              result_reg;

    logic [ACC_W-1:0]     sum_wide;
    logic [SUM_W-1:0]     sum_sat;
    logic [GCW-1:0]       gcnt_inc;

    assign q_pop        = pop_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    lpd_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start_reg),
        .operand (sq_op_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    always_comb
    begin
        sum_wide = ACC_W'(sum_reg) + ACC_W'(term_reg);
        sum_sat  = (sum_wide > ACC_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
        gcnt_inc = gcnt_reg + 1'b1;
    end

    // Single shared squarer; mul_op_reg is squared into the registered prod_reg.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_op_reg) * PROD_W'(mul_op_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            entry_reg        <= '0;
            sum_reg          <= '0;
            limit_reg        <= '0;
            term_reg         <= '0;
            res_reg          <= '0;
            gcnt_reg         <= '0;
            abandon_reg      <= 1'b0;
            start_reg        <= 1'b1;
            pop_reg          <= 1'b0;
            mul_op_reg       <= '0;
            sq_start_reg     <= 1'b0;
            sq_op_reg        <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            pop_reg      <= 1'b0;
            sq_start_reg <= 1'b0;
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        entry_reg <= q_entry;
                        pop_reg   <= 1'b1;
                        state_reg <= ST_LIMIT;
                    end
                end
                ST_LIMIT:
                begin
                    state_reg <= ST_TERM;
                    if (start_reg)
                    begin
                        start_reg <= 1'b0;
                        case (entry_reg.mode)
                            MODE_L2:
                            begin
                                if (entry_reg.limit >= SQ_LIMIT)
                                begin
                                    limit_reg <= SUM_MAX;
                                end
                                else
                                begin
                                    mul_op_reg <= entry_reg.limit[MUL_W-1:0];
                                    state_reg  <= ST_LIM_MUL;
                                end
                            end
                            MODE_L05:
                            begin
                                sq_op_reg    <= SQ_IN_W'(entry_reg.limit) << FRAC;
                                sq_start_reg <= 1'b1;
                                state_reg    <= ST_LIM_SQRT;
                            end
                            default:
                            begin
                                limit_reg <= entry_reg.limit;
                            end
                        endcase
                    end
                end
                ST_LIM_MUL:
                begin
                    state_reg <= ST_LIM_PROD;
                end
                ST_LIM_PROD:
                begin
                    limit_reg <= SUM_W'(prod_reg >> FRAC);
                    state_reg <= ST_TERM;
                end
                ST_LIM_SQRT:
                begin
                    if (sq_done)
                    begin
                        limit_reg <= SUM_W'(sq_root);
                        state_reg <= ST_TERM;
                    end
                end
                ST_TERM:
                begin
                    if (abandon_reg)
                    begin
                        // A frozen sum takes no more terms and no more checks.
                        state_reg <= entry_reg.last ? ST_FIN : ST_IDLE;
                    end
                    else
                    begin
                        case (entry_reg.mode)
                            MODE_L2:
                            begin
                                mul_op_reg <= MUL_W'(entry_reg.diff);
                                state_reg  <= ST_TERM_MUL;
                            end
                            MODE_L05:
                            begin
                                sq_op_reg    <= SQ_IN_W'(entry_reg.diff) << (2 * FRAC);
                                sq_start_reg <= 1'b1;
                                state_reg    <= ST_TERM_SQRT;
                            end
                            default:
                            begin
                                term_reg  <= TERM_W'(entry_reg.diff) << FRAC;
                                state_reg <= ST_ACC;
                            end
                        endcase
                    end
                end
                ST_TERM_MUL:
                begin
                    state_reg <= ST_TERM_PROD;
                end
                ST_TERM_PROD:
                begin
                    term_reg  <= TERM_W'(prod_reg) << FRAC;
                    state_reg <= ST_ACC;
                end
                ST_TERM_SQRT:
                begin
                    if (sq_done)
                    begin
                        term_reg  <= TERM_W'(sq_root);
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    sum_reg <= sum_sat;
                    if (gcnt_inc >= GCW'(GROUP_SIZE))
                    begin
                        gcnt_reg <= '0;
                        if (!entry_reg.last && (sum_sat > limit_reg))
                        begin
                            abandon_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        gcnt_reg <= gcnt_inc;
                    end
                    state_reg <= entry_reg.last ? ST_FIN : ST_IDLE;
                end
                ST_FIN:
                begin
                    case (entry_reg.mode)
                        MODE_L2:
                        begin
                            sq_op_reg    <= SQ_IN_W'(sum_reg) << FRAC;
                            sq_start_reg <= 1'b1;
                            state_reg    <= ST_FIN_SQRT;
                        end
                        MODE_L05:
                        begin
                            if (sum_reg >= SQ_LIMIT)
                            begin
                                res_reg   <= SUM_MAX;
                                state_reg <= ST_OUT;
                            end
                            else
                            begin
                                mul_op_reg <= sum_reg[MUL_W-1:0];
                                state_reg  <= ST_FIN_MUL;
                            end
                        end
                        default:
                        begin
                            res_reg   <= sum_reg;
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_FIN_MUL:
                begin
                    state_reg <= ST_FIN_PROD;
                end
                ST_FIN_PROD:
                begin
                    res_reg   <= SUM_W'(prod_reg >> FRAC);
                    state_reg <= ST_OUT;
                end
                ST_FIN_SQRT:
                begin
                    if (sq_done)
                    begin
                        res_reg   <= SUM_W'(sq_root);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!result_valid_reg || result_ready)
                    begin
                        result_reg.distance  <= res_reg;
                        result_reg.abandoned <= abandon_reg;
                        result_valid_reg     <= 1'b1;
                        sum_reg              <= '0;
                        gcnt_reg             <= '0;
                        abandon_reg          <= 1'b0;
                        start_reg            <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/lp_distance_early_abandon.sv
// Usage: the item channel takes one element pair per word (elem_a, elem_b, abandon_limit,
// vec_last) under valid/ready; abandon_limit is sampled only on a vector's first word.
// The result channel gives one word (distance, abandoned) for each word marked vec_last.
// The norm is chosen by the norm_mode register, written through cfg_wen/cfg_wdata while
// the block is idle; code 3 acts as L1.
// Structure: a two-entry queue sits between the front end and a sequential back end that
// handles one word at a time. An L1 word passes through the term and accumulate states,
// an L2 word also through the shared squarer, and an L0.5 word waits on the square-root
// unit (load, one iteration per root bit, done). The first word of a vector adds the
// limit conversion (squarer for L2, square root for L0.5), the last word the final
// transform (square root for L2, squarer for L0.5, none for L1) and the output load.
// Reset clears the queue, the running sum and the flags, and sets norm_mode to L2.
// A stalled receiver holds the result register; the back end stalls only when a second
// result is ready, and the front keeps taking words until the queue is full.
module lp_distance_early_abandon
    import lpd_pkg::*;
#(
    parameter int GROUP_SIZE = GROUP_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [1:0] cfg_wdata,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);

    logic [1:0] norm_mode_reg;
    logic       q_valid;
    logic       q_pop;
    entry_t     q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_mode_reg <= MODE_L2;
        end
        else if (cfg_wen)
        begin
            norm_mode_reg <= cfg_wdata;
        end
    end

    lpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .norm_mode  (norm_mode_reg),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop)
    );

    lpd_back #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> tb/tb_lp_distance_early_abandon.sv
// Self-checking testbench for the Lp distance block with early abandon.
module tb_lp_distance_early_abandon;
    import lpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRP = 8;
    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    logic [1:0] cfg_wdata;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;

    lp_distance_early_abandon u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wen(cfg_wen),
        .cfg_wdata(cfg_wdata),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Shadow state of the distance engine.
    logic [1:0] sh_mode;
    logic [47:0] sh_sum;
    int sh_grp;
    logic [47:0] sh_limit;
    logic sh_abandon;
    logic sh_start;

    item_t word_q[$];
    result_t dist_expect_q[$];
    int fail_cnt;
    bit no_idle;
    logic hold_req;
    logic hold_seen;
    bit word_taken;
    int idle_cycles;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [47:0] sq_scaled(input logic [47:0] v);
        logic [63:0] s;
        if (v >= (48'd1 << 28))
            return MAX48;
        s = ({16'd0, v} * {16'd0, v}) >> 8;
        return (s > {16'd0, MAX48}) ? MAX48 : s[47:0];
    endfunction

    function automatic norm_t eff_mode(input logic [1:0] m);
        return (m == 2'd3) ? MODE_L1 : norm_t'(m);
    endfunction

    task automatic lp_predict(input item_t w);
        norm_t m;
        logic [63:0] d;
        logic [63:0] term;
        logic [63:0] s;
        result_t r;
        m = eff_mode(sh_mode);
        if (sh_start)
        begin
            case (m)
                MODE_L2: sh_limit = sq_scaled(w.abandon_limit);
                MODE_L05: sh_limit = 48'(int_sqrt({8'd0, w.abandon_limit, 8'd0}));
                default: sh_limit = w.abandon_limit;
            endcase
            sh_start = 1'b0;
        end
        if (!sh_abandon)
        begin
            d = (w.elem_a > w.elem_b) ? 64'(int'(w.elem_a) - int'(w.elem_b))
                                      : 64'(int'(w.elem_b) - int'(w.elem_a));
            case (m)
                MODE_L2: term = (d * d) << 8;
                MODE_L05: term = int_sqrt(d << 16);
                default: term = d << 8;
            endcase
            s = {16'd0, sh_sum} + term;
            sh_sum = (s > {16'd0, MAX48}) ? MAX48 : s[47:0];
            sh_grp++;
            if (sh_grp >= GRP)
            begin
                sh_grp = 0;
                if (!w.vec_last && sh_sum > sh_limit)
                    sh_abandon = 1'b1;
            end
        end
        if (w.vec_last)
        begin
            case (m)
                MODE_L2: r.distance = 48'(int_sqrt({8'd0, sh_sum, 8'd0}));
                MODE_L05: r.distance = sq_scaled(sh_sum);
                default: r.distance = sh_sum;
            endcase
            r.abandoned = sh_abandon;
            dist_expect_q.push_back(r);
            sh_sum = 0;
            sh_grp = 0;
            sh_abandon = 1'b0;
            sh_start = 1'b1;
        end
    endtask

    // Acceptance, prediction and result checking all happen at the rising edge.
    always @(posedge clk)
    begin
        word_taken = item_valid && item_ready;
        if (word_taken)
            lp_predict(item);
        if (result_valid && result_ready)
        begin
            if (dist_expect_q.size() == 0)
            begin
                $error("unexpected result word: distance %h abandoned %b",
                       result.distance, result.abandoned);
                fail_cnt++;
            end
            else
            begin
                if (result.distance !== dist_expect_q[0].distance)
                begin
                    $error("distance: expected %h, got %h",
                           dist_expect_q[0].distance, result.distance);
                    fail_cnt++;
                end
                if (result.abandoned !== dist_expect_q[0].abandoned)
                begin
                    $error("abandoned: expected %b, got %b",
                           dist_expect_q[0].abandoned, result.abandoned);
                    fail_cnt++;
                end
                void'(dist_expect_q.pop_front());
            end
        end
        if (word_taken || (result_valid && result_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    int send_gap;

    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (item_valid && !word_taken)
            item_valid <= 1'b1;
        else if (send_gap > 0)
        begin
            send_gap--;
            item_valid <= 1'b0;
        end
        else if (word_q.size() > 0)
        begin
            item <= word_q.pop_front();
            item_valid <= 1'b1;
            send_gap = no_idle ? 0 : pick_gap();
        end
        else
            item_valid <= 1'b0;
    end

    int recv_stall;

    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            recv_stall = 400;
        end
        if (recv_stall > 0)
        begin
            recv_stall--;
            result_ready <= 1'b0;
        end
        else if (no_idle || $urandom_range(0, 2) != 0)
            result_ready <= 1'b1;
        else
        begin
            result_ready <= 1'b0;
            recv_stall = pick_gap();
        end
    end

    task automatic wait_idle();
        while (word_q.size() > 0 || item_valid || dist_expect_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_wen <= 1'b0;
        sh_mode = m;
    endtask

    function automatic logic signed [15:0] rand_elem(input int style);
        case (style)
            1: return 16'($urandom_range(0, 15)) - 16'sd8;
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return 48'd0;
            1: return 48'({$urandom, $urandom});
            2: return 48'($urandom_range(0, 1 << 20));
            3: return 48'($urandom) << $urandom_range(0, 16);
            4: return MAX48;
            default: return 48'($urandom_range(0, 1 << 26));
        endcase
    endfunction

    // Queues the words of one vector; with close set to 0 no word is marked vec_last.
    task automatic add_vector(input int len, input logic [47:0] lim, input int style,
                              input bit close);
        item_t w;
        for (int i = 0; i < len; i++)
        begin
            w.elem_a = rand_elem(style);
            w.elem_b = rand_elem(style);
            w.abandon_limit = (i == 0) ? lim : 48'({$urandom, $urandom});
            w.vec_last = close && (i == len - 1);
            word_q.push_back(w);
        end
    endtask

    int words_sent;
    int vlen;
    item_t xw;

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = 2'd0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        hold_req = 1'b0;
        hold_seen = 1'b0;
        no_idle = 1'b0;
        fail_cnt = 0;
        send_gap = 0;
        recv_stall = 0;
        idle_cycles = 0;
        word_taken = 0;
        sh_mode = 2'd1;
        sh_sum = 0;
        sh_grp = 0;
        sh_limit = 0;
        sh_abandon = 1'b0;
        sh_start = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset mode first, then each mode with extreme words.
        for (int m = 1; m <= 4; m++)
        begin
            if (m != 1)
                write_mode(2'(m % 4));
            xw.elem_a = 16'sh8000;
            xw.elem_b = 16'sh7FFF;
            xw.abandon_limit = MAX48;
            xw.vec_last = 1'b1;
            word_q.push_back(xw);
            xw.elem_a = 16'sh7FFF;
            xw.elem_b = 16'sh8000;
            xw.abandon_limit = 48'd0;
            word_q.push_back(xw);
            add_vector(8, 48'd0, 2, 1);
            add_vector(9, 48'd0, 2, 1);
            wait_idle();
        end

        // A mode change in the middle of a vector keeps the first conversion.
        write_mode(2'd2);
        add_vector(5, 48'd1000, 0, 0);
        wait_idle();
        write_mode(2'd1);
        add_vector(12, 48'd0, 0, 1);
        wait_idle();

        // Saturating sum against a saturated limit must not abandon.
        add_vector(300, MAX48, 2, 1);
        wait_idle();

        // Receiver holds off while the sender keeps offering words.
        write_mode(2'd0);
        for (int v = 0; v < 20; v++)
            add_vector(2, rand_limit(), 0, 1);
        hold_req = ~hold_req;
        wait_idle();

        words_sent = 0;
        while (words_sent < 600)
        begin
            write_mode(2'($urandom_range(0, 3)));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int v = 0; v < 8; v++)
            begin
                vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 20);
                add_vector(vlen, rand_limit(), $urandom_range(0, 2), 1);
                words_sent += vlen;
            end
            wait_idle();
        end
        no_idle = 1'b0;

        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
